### hw/rtl/dwsr_pkg.sv
// shared types, operation and status codes for the deque with search and remove
package dwsr_pkg;

   // default store depth
   localparam int DEPTH_DEF = 64;

   // field widths
   localparam int KEY_W  = 32;
   localparam int MODE_W = 3;
   localparam int STAT_W = 2;
   localparam int POS_W  = 7;

   typedef logic [MODE_W-1:0]       mode_type;
   typedef logic [STAT_W-1:0]       status_type;
   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [POS_W-1:0]        pos_type;

   // operation codes
   localparam mode_type MODE_INS_FRONT  = 3'd0;
   localparam mode_type MODE_INS_BACK   = 3'd1;
   localparam mode_type MODE_DEL_FRONT  = 3'd2;
   localparam mode_type MODE_DEL_BACK   = 3'd3;
   localparam mode_type MODE_FIND       = 3'd4;
   localparam mode_type MODE_REMOVE_ALL = 3'd5;
   localparam mode_type MODE_CLEAR      = 3'd6;

   // status codes
   localparam status_type STAT_OK        = 2'd0;
   localparam status_type STAT_EMPTY     = 2'd1;
   localparam status_type STAT_FULL      = 2'd2;
   localparam status_type STAT_NOT_FOUND = 2'd3;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_HOLD
   } state_type;

endpackage

### hw/rtl/dwsr_if.sv
// request and response channel interfaces
interface dwsr_req_if
   import dwsr_pkg::*;
();
   logic     valid;
   logic     ready;
   mode_type mode;
   key_type  key_in;

   modport source (output valid, output mode, output key_in, input ready);
   modport sink   (input valid, input mode, input key_in, output ready);
endinterface

interface dwsr_rsp_if
   import dwsr_pkg::*;
();
   logic       valid;
   logic       ready;
   status_type status;
   key_type    key_out;
   pos_type    position;

   modport source (output valid, output status, output key_out, output position, input ready);
   modport sink   (input valid, input status, input key_out, input position, output ready);
endinterface

### hw/rtl/dwsr_mem.sv
// key store: one write port, one read port with registered read data
module dwsr_mem
   import dwsr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  key_type       wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output key_type       rd_data
);

   key_type mem [DEPTH];
   key_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/deque_with_search_and_remove.sv
// Double-ended queue of signed 32-bit keys held in a DEPTH-entry ring memory.
// One word in, one word out. Inserts, clears, and deletes, finds and remove-alls
// on an empty queue finish in the accept cycle; front and back deletes finish
// in the read state from the registered memory read data. Find and remove-all
// stream the queue through the memory read port one entry per cycle: find ends
// at the first match or after the last entry; remove-all ends after the last
// entry, compacting the survivors in place through the write port. A new
// request word is taken once the previous one has finished and its response
// sits in the output register; the response waits there for the consumer
// without holding up the next request. The store needs no clearing after reset.
module deque_with_search_and_remove
   import dwsr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   dwsr_req_if.sink   req_chan,
   dwsr_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

   // ring address of a sum below twice the depth
   function automatic logic [AW-1:0] wrap(input logic [SW-1:0] a);
      logic [SW-1:0] d;
      d = a - DEPTH_S;
      if (a >= DEPTH_S) begin
         return d[AW-1:0];
      end
      return a[AW-1:0];
   endfunction

   // count to position field, modulo its width
   function automatic pos_type to_pos(input logic [CW-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[POS_W-1:0];
   endfunction

   // control and pointer registers
   state_type     state_ff, state_in;
   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   mode_type      op_ff, op_in;
   key_type       key_ff, key_in;
   logic [CW-1:0] rd_pos_ff, rd_pos_in;
   logic [CW-1:0] dpos_ff, dpos_in;
   logic [CW-1:0] kept_ff, kept_in;

   // output register and pending result
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   key_type    rsp_key_ff, rsp_key_in;
   pos_type    rsp_pos_ff, rsp_pos_in;
   status_type pend_status_ff, pend_status_in;
   key_type    pend_key_ff, pend_key_in;
   pos_type    pend_pos_ff, pend_pos_in;

   // memory port signals
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   key_type       mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   key_type       mem_rd_data;

   // finished result of the current word
   logic       done;
   status_type done_status;
   key_type    done_key;
   pos_type    done_pos;

   // shared conditions and addresses
   logic          accept;
   logic          out_free;
   logic          is_full;
   logic          is_empty;
   logic          match;
   logic          last;
   logic [CW-1:0] kept_next;
   logic [AW-1:0] slot_front_m1;
   logic [AW-1:0] slot_front_p1;
   logic [AW-1:0] slot_back;
   logic [AW-1:0] slot_last;
   logic [AW-1:0] slot_rd;
   logic [AW-1:0] slot_kept;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign is_full        = (count_ff == CW'(DEPTH));
   assign is_empty       = (count_ff == '0);
   assign match          = (mem_rd_data == key_ff);
   assign last           = (dpos_ff == count_ff - CW'(1));
   assign kept_next      = match ? kept_ff : kept_ff + CW'(1);

   assign slot_front_m1 = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign slot_front_p1 = wrap(SW'(front_ff) + SW'(1));
   assign slot_back     = wrap(SW'(front_ff) + SW'(count_ff));
   assign slot_last     = wrap(SW'(front_ff) + SW'(count_ff) - SW'(1));
   assign slot_rd       = wrap(SW'(front_ff) + SW'(rd_pos_ff));
   assign slot_kept     = wrap(SW'(front_ff) + SW'(kept_ff));

   dwsr_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (done) begin
                  state_in = out_free ? ST_IDLE : ST_HOLD;
               end else if (req_chan.mode == MODE_DEL_FRONT ||
                            req_chan.mode == MODE_DEL_BACK) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_READ, ST_SCAN: begin
            if (done) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath, memory control and result
   always_comb begin
      front_in       = front_ff;
      count_in       = count_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      rd_pos_in      = rd_pos_ff;
      dpos_in        = dpos_ff;
      kept_in        = kept_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = slot_kept;
      mem_wr_data    = mem_rd_data;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = slot_rd;
      done           = 1'b0;
      done_status    = STAT_OK;
      done_key       = '0;
      done_pos       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in  = req_chan.mode;
               key_in = req_chan.key_in;
               case (req_chan.mode)
                  MODE_INS_FRONT: begin
                     done = 1'b1;
                     if (is_full) begin
                        done_status = STAT_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = slot_front_m1;
                        mem_wr_data = req_chan.key_in;
                        front_in    = slot_front_m1;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  MODE_INS_BACK: begin
                     done = 1'b1;
                     if (is_full) begin
                        done_status = STAT_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = slot_back;
                        mem_wr_data = req_chan.key_in;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  MODE_DEL_FRONT: begin
                     if (is_empty) begin
                        done        = 1'b1;
                        done_status = STAT_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = front_ff;
                        front_in    = slot_front_p1;
                        count_in    = count_ff - CW'(1);
                     end
                  end
                  MODE_DEL_BACK: begin
                     if (is_empty) begin
                        done        = 1'b1;
                        done_status = STAT_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = slot_last;
                        count_in    = count_ff - CW'(1);
                     end
                  end
                  MODE_FIND, MODE_REMOVE_ALL: begin
                     if (is_empty) begin
                        done        = 1'b1;
                        done_status = (req_chan.mode == MODE_FIND) ? STAT_NOT_FOUND : STAT_OK;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = front_ff;
                        rd_pos_in   = CW'(1);
                        dpos_in     = '0;
                        kept_in     = '0;
                     end
                  end
                  MODE_CLEAR: begin
                     done     = 1'b1;
                     count_in = '0;
                     front_in = '0;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            done     = 1'b1;
            done_key = mem_rd_data;
         end
         ST_SCAN: begin
            // stream the next entry out of the memory
            if (rd_pos_ff < count_ff) begin
               mem_rd_en = 1'b1;
               rd_pos_in = rd_pos_ff + CW'(1);
            end
            dpos_in = rd_pos_ff;
            if (op_ff == MODE_FIND) begin
               if (match) begin
                  done     = 1'b1;
                  done_pos = to_pos(dpos_ff);
               end else if (last) begin
                  done        = 1'b1;
                  done_status = STAT_NOT_FOUND;
               end
            end else begin
               // compact survivors toward the front
               if (!match) begin
                  mem_wr_en = 1'b1;
               end
               kept_in = kept_next;
               if (last) begin
                  done     = 1'b1;
                  done_pos = to_pos(count_ff - kept_next);
                  count_in = kept_next;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // output register and pending result
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_pos_in     = rsp_pos_ff;
      pend_status_in = pend_status_ff;
      pend_key_in    = pend_key_ff;
      pend_pos_in    = pend_pos_ff;
      if (done) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = done_status;
            rsp_key_in    = done_key;
            rsp_pos_in    = done_pos;
         end else begin
            pend_status_in = done_status;
            pend_key_in    = done_key;
            pend_pos_in    = done_pos;
         end
      end else if (state_ff == ST_HOLD && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_key_in    = pend_key_ff;
         rsp_pos_in    = pend_pos_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.key_out  = rsp_key_ff;
   assign rsp_chan.position = rsp_pos_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      rd_pos_ff      <= rd_pos_in;
      dpos_ff        <= dpos_in;
      kept_ff        <= kept_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_pos_ff     <= rsp_pos_in;
      pend_status_ff <= pend_status_in;
      pend_key_ff    <= pend_key_in;
      pend_pos_ff    <= pend_pos_in;
   end

endmodule
